[hw/rtl/esld_pkg.sv]
// ----------------------------------------------------------------------------
// esld_pkg
// Shared widths, types and constants of the expert slot LRU directory.
// ----------------------------------------------------------------------------
package esld_pkg;

    localparam int unsigned LAYER_W  = 6;
    localparam int unsigned EXPERT_W = 8;
    localparam int unsigned STAMP_W  = 48;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CFG_W    = 10;

    // capacity after reset
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 10'd384;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [LAYER_W-1:0]  layer;
        logic [EXPERT_W-1:0] expert;
    } t_tag;

    // one directory entry: tag and last-use stamp
    typedef struct packed {
        t_tag               tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

[hw/rtl/expert_slot_lru_directory.sv]
// Flow: an accepted request passes ST_SCAN (skipped when no slot is filled), ST_DECIDE and
//   ST_OUT; the scan reads one entry per cycle from the single-port directory memory (tag and
//   stamp read together). A new lookup is taken only in ST_IDLE; a result not yet taken holds
//   the block in the result stage until the output register frees.
// Reset: synchronous, active low; clears fill count, use clock, hit/miss totals
//   and sets the capacity register to 384. The directory memory is not cleared.
// ----------------------------------------------------------------------------
// expert_slot_lru_directory
// Fully associative tag directory with least-recently-used replacement.
// ----------------------------------------------------------------------------
module expert_slot_lru_directory #(
    parameter int unsigned SLOTS = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [esld_pkg::CFG_W-1:0]             i_cfg_wdata,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [esld_pkg::LAYER_W-1:0]           i_layer_id,
    input  logic [esld_pkg::EXPERT_W-1:0]          i_expert_id,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [$clog2(SLOTS)-1:0]               o_slot_index,
    output logic                                   o_was_hit,
    output logic                                   o_evicted_valid,
    output logic [esld_pkg::LAYER_W-1:0]           o_evicted_layer,
    output logic [esld_pkg::EXPERT_W-1:0]          o_evicted_expert,
    output logic [esld_pkg::COUNT_W-1:0]           o_hit_total,
    output logic [esld_pkg::COUNT_W-1:0]           o_miss_total
);

    localparam int unsigned SlotW = $clog2(SLOTS);
    localparam int unsigned CntW  = $clog2(SLOTS + 1);
    localparam logic [31:0] SlotsW32 = 32'(SLOTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    // directory memory
    esld_pkg::t_entry r_mem [SLOTS];
    esld_pkg::t_entry r_rd_data;

    // control state
    logic [1:0]                      r_state;
    logic [esld_pkg::CFG_W-1:0]      r_active_slots;
    logic [CntW-1:0]                 r_filled_count;
    logic [esld_pkg::STAMP_W-1:0]    r_use_clock;
    logic [esld_pkg::COUNT_W-1:0]    r_hit_counter;
    logic [esld_pkg::COUNT_W-1:0]    r_miss_counter;
    logic [CntW-1:0]                 r_addr;
    logic                            r_rd_vld;
    logic                            r_hit;
    logic                            r_min_first;
    logic                            r_o_valid;

    // payload state
    esld_pkg::t_tag                  r_req_tag;
    logic [SlotW-1:0]                r_rd_idx;
    logic [SlotW-1:0]                r_hit_idx;
    logic [SlotW-1:0]                r_min_idx;
    logic [esld_pkg::STAMP_W-1:0]    r_min_stamp;
    esld_pkg::t_tag                  r_min_tag;
    logic [SlotW-1:0]                r_res_slot;
    logic                            r_res_hit;
    logic                            r_res_evict;
    esld_pkg::t_tag                  r_res_ev_tag;
    logic [SlotW-1:0]                r_o_slot;
    logic                            r_o_hit;
    logic                            r_o_evict;
    esld_pkg::t_tag                  r_o_ev_tag;
    logic [esld_pkg::COUNT_W-1:0]    r_o_hit_total;
    logic [esld_pkg::COUNT_W-1:0]    r_o_miss_total;

    // combinational
    logic [31:0]                     w_act32;
    logic [CntW-1:0]                 w_cap;
    logic                            w_full;
    logic                            w_in_xfer;
    logic                            w_rd_en;
    logic                            w_wr_en;
    logic                            w_out_free;
    logic                            w_match;
    logic                            w_older;
    logic [SlotW-1:0]                n_slot;
    logic [esld_pkg::STAMP_W-1:0]    n_use_clock;
    esld_pkg::t_entry                w_wr_data;

    // capacity, clamped to 1..SLOTS
    always_comb begin
        w_act32 = 32'(r_active_slots);
        if (w_act32 == 32'd0) begin
            w_cap = CntW'(1);
        end else if (w_act32 > SlotsW32) begin
            w_cap = CntW'(SLOTS);
        end else begin
            w_cap = CntW'(w_act32);
        end
    end

    assign w_full     = (r_filled_count >= w_cap);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_rd_en    = (r_state == ST_SCAN) && (r_addr < r_filled_count);
    assign w_wr_en    = (r_state == ST_DECIDE);
    assign w_out_free = !r_o_valid || i_ready;
    assign w_match    = r_rd_vld && (r_rd_data.tag == r_req_tag);
    assign w_older    = r_rd_vld && (r_min_first || (r_rd_data.stamp < r_min_stamp));
    assign n_use_clock = r_use_clock + esld_pkg::STAMP_W'(1);

    // slot chosen for this request
    always_comb begin
        if (r_hit) begin
            n_slot = r_hit_idx;
        end else if (w_full) begin
            n_slot = r_min_idx;
        end else begin
            n_slot = r_filled_count[SlotW-1:0];
        end
    end

    assign w_wr_data.tag   = r_req_tag;
    assign w_wr_data.stamp = n_use_clock;

    // memory: one read or one write per cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr[SlotW-1:0]];
        end
        if (w_wr_en) begin
            r_mem[n_slot] <= w_wr_data;
        end
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active_slots <= esld_pkg::ACTIVE_SLOTS_RST;
            r_filled_count <= '0;
            r_use_clock    <= '0;
            r_hit_counter  <= '0;
            r_miss_counter <= '0;
            r_addr         <= '0;
            r_rd_vld       <= 1'b0;
            r_hit          <= 1'b0;
            r_min_first    <= 1'b1;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_slots <= i_cfg_wdata;
            end
            // result register: load when leaving the result stage, clear on transfer
            if (r_state == ST_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_addr      <= '0;
                        r_rd_vld    <= 1'b0;
                        r_hit       <= 1'b0;
                        r_min_first <= 1'b1;
                        r_state     <= (r_filled_count == '0) ? ST_DECIDE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= w_rd_en;
                    if (w_rd_en) begin
                        r_addr <= r_addr + CntW'(1);
                    end
                    // first match wins
                    if (w_match && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (w_older) begin
                        r_min_first <= 1'b0;
                    end
                    if (!w_rd_en && !r_rd_vld) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_use_clock <= n_use_clock;
                    if (r_hit) begin
                        if (r_hit_counter != esld_pkg::COUNT_MAX) begin
                            r_hit_counter <= r_hit_counter + esld_pkg::COUNT_W'(1);
                        end
                    end else begin
                        if (r_miss_counter != esld_pkg::COUNT_MAX) begin
                            r_miss_counter <= r_miss_counter + esld_pkg::COUNT_W'(1);
                        end
                        if (!w_full) begin
                            r_filled_count <= r_filled_count + CntW'(1);
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // scan trackers and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_xfer) begin
            r_req_tag.layer  <= i_layer_id;
            r_req_tag.expert <= i_expert_id;
        end
        if (w_rd_en) begin
            r_rd_idx <= r_addr[SlotW-1:0];
        end
        if (r_state == ST_SCAN && w_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_state == ST_SCAN && w_older) begin
            r_min_idx   <= r_rd_idx;
            r_min_stamp <= r_rd_data.stamp;
            r_min_tag   <= r_rd_data.tag;
        end
        if (r_state == ST_DECIDE) begin
            r_res_slot  <= n_slot;
            r_res_hit   <= r_hit;
            r_res_evict <= !r_hit && w_full;
            r_res_ev_tag <= (!r_hit && w_full) ? r_min_tag : '0;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_o_slot       <= r_res_slot;
            r_o_hit        <= r_res_hit;
            r_o_evict      <= r_res_evict;
            r_o_ev_tag     <= r_res_ev_tag;
            r_o_hit_total  <= r_hit_counter;
            r_o_miss_total <= r_miss_counter;
        end
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_slot_index     = r_o_slot;
    assign o_was_hit        = r_o_hit;
    assign o_evicted_valid  = r_o_evict;
    assign o_evicted_layer  = r_o_ev_tag.layer;
    assign o_evicted_expert = r_o_ev_tag.expert;
    assign o_hit_total      = r_o_hit_total;
    assign o_miss_total     = r_o_miss_total;

    // scan never runs past the filled region
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_addr <= r_filled_count)
        else $error("scan address beyond filled slots");

    // a decision is always followed by the result stage
    a_decide_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DECIDE |=> r_state == ST_OUT)
        else $error("decision not followed by result stage");

    // the use clock advances once per request
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DECIDE |=> r_use_clock == $past(r_use_clock) + 48'd1)
        else $error("use clock did not advance");

    // a miss with free capacity takes a new slot
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && !r_hit && !w_full)
        |=> r_filled_count == $past(r_filled_count) + CntW'(1))
        else $error("fill count not advanced on miss");

    // hit and eviction exclude each other
    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_was_hit && o_evicted_valid))
        else $error("hit reported together with eviction");

endmodule
